/* design/deque_with_search_removal_macros.svh */
// ----------------------------------------------------------------------------
// deque_with_search_removal_macros
// Assertion macros shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_REMOVAL_MACROS_SVH
`define DEQUE_WITH_SEARCH_REMOVAL_MACROS_SVH

// condition holds in the same cycle as the trigger
`define DWSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dwsr assertion failed");

// condition holds in the cycle after the trigger
`define DWSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dwsr assertion failed");

`endif

/* design/dwsr_pkg.sv */
// ----------------------------------------------------------------------------
// dwsr_pkg
// Types, codes and constants of the deque with search and removal.
// ----------------------------------------------------------------------------
`default_nettype none

package dwsr_pkg;

  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned ACTION_W   = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POSITION_W = 8;
  localparam int unsigned COUNT_W    = 7;

  localparam logic [DATA_W-1:0] VAL_FAIL  = '1;
  localparam logic [DATA_W-1:0] VAL_CLEAR = '0;

  // request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND      = 4'd0,
    ACT_PUSH_FRONT  = 4'd1,
    ACT_POP_FRONT   = 4'd2,
    ACT_POP_BACK    = 4'd3,
    ACT_PEEK_FRONT  = 4'd4,
    ACT_PEEK_BACK   = 4'd5,
    ACT_READ_INDEX  = 4'd6,
    ACT_CONTAINS    = 4'd7,
    ACT_REMOVE_EQ   = 4'd8,
    ACT_HAS_GREATER = 4'd9,
    ACT_TAKE_GREATER = 4'd10,
    ACT_HAS_SMALLER = 4'd11,
    ACT_TAKE_SMALLER = 4'd12,
    ACT_CLEAR       = 4'd13
  } action_e;

  // what a cell flags as a hit in the compare cycle
  typedef enum logic [2:0] {
    HIT_NONE,
    HIT_EQ,
    HIT_GT,
    HIT_LT,
    HIT_POS,
    HIT_FRONT,
    HIT_BACK
  } hit_e;

  // how the cells update their entries in the apply cycle
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHIFT_IN,
    MODE_REMOVE,
    MODE_WRITE_TAIL
  } mode_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  // broadcast to all cells on the compare cycle
  typedef struct packed {
    logic                  load;
    hit_e                  kind;
    logic [DATA_W-1:0]     operand;
    logic [POSITION_W-1:0] position;
  } cell_eval_t;

  // broadcast to all cells on the apply cycle
  typedef struct packed {
    logic              apply;
    mode_e             mode;
    logic [DATA_W-1:0] operand;
  } cell_upd_t;

  // hit kind that an action asks the cells for
  function automatic hit_e hit_of(logic [ACTION_W-1:0] act);
    hit_e k;
    case (act)
      ACT_POP_FRONT, ACT_PEEK_FRONT:      k = HIT_FRONT;
      ACT_POP_BACK, ACT_PEEK_BACK:        k = HIT_BACK;
      ACT_READ_INDEX:                     k = HIT_POS;
      ACT_CONTAINS, ACT_REMOVE_EQ:        k = HIT_EQ;
      ACT_HAS_GREATER, ACT_TAKE_GREATER:  k = HIT_GT;
      ACT_HAS_SMALLER, ACT_TAKE_SMALLER:  k = HIT_LT;
      default:                            k = HIT_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/dwsr_intf.sv */
// ----------------------------------------------------------------------------
// dwsr_intf
// Request and response channels of the deque, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwsr_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [dwsr_pkg::ACTION_W-1:0]         action;
  logic signed [dwsr_pkg::DATA_W-1:0]    operand;
  logic [dwsr_pkg::POSITION_W-1:0]       position;

  modport source (output valid, action, operand, position, input ready);
  modport sink   (input valid, action, operand, position, output ready);
endinterface

interface dwsr_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic signed [dwsr_pkg::DATA_W-1:0]    result_value;
  logic [dwsr_pkg::COUNT_W-1:0]          count;

  modport source (output valid, ok, result_value, count, input ready);
  modport sink   (input valid, ok, result_value, count, output ready);
endinterface

`default_nettype wire

/* design/deque_with_search_removal.sv */
// ----------------------------------------------------------------------------
// deque_with_search_removal
// Double-ended queue of signed words with search, take and remove by value,
// built as a row of cells that compare in parallel and shift as one.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+---------------------------------
//  req_i    | in  | valid / ready    | action, operand, position
//  rsp_o    | out | valid / ready    | ok, result_value, count
//
//  one item at a time: on the accept edge every cell compares its entry
//  and registers a hit flag; when the apply step fires, the first-match
//  chain picks the entry, the cells shift or write, and the result is registered.
//  reset clears the count, the sequencer, the hit flags and the response
//  valid flag; the entries are not reset and need no clearing pass.
//  a result that is not taken holds the apply step and keeps req_i.ready low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deque_with_search_removal_macros.svh"

module deque_with_search_removal #(
  parameter int unsigned Depth = dwsr_pkg::DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dwsr_req_if.sink    req_i,
  dwsr_rsp_if.source  rsp_o
);
  import dwsr_pkg::*;

  localparam int unsigned CntW = $clog2(Depth+1);

  state_e              state_q, state_d;
  logic [ACTION_W-1:0] act_q;
  logic [DATA_W-1:0]   op_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                req_fire, apply_fire;

  logic                rsp_valid_q;
  logic                rsp_ok_q;
  logic [DATA_W-1:0]   rsp_val_q;
  logic [COUNT_W-1:0]  rsp_cnt_q;

  logic                ok_d;
  logic [DATA_W-1:0]   val_d;
  mode_e               mode_d;
  logic [CntW+COUNT_W-1:0] cnt_ext;

  cell_eval_t          eval;
  cell_upd_t           upd;

  logic [DATA_W-1:0]   entry_w [Depth];
  logic [DATA_W-1:0]   sel_w   [Depth];
  logic [Depth:0]      seen_w;
  logic [Depth-1:0]    first_w;
  logic [DATA_W-1:0]   sel_val;
  logic                hit_any;

  // handshake
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign apply_fire  = (state_q == ST_APPLY) && (!rsp_valid_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (req_fire) state_d = ST_APPLY;
      ST_APPLY: if (apply_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q <= req_i.action;
      op_q  <= req_i.operand;
    end
  end

  // compare broadcast
  assign eval.load     = req_fire;
  assign eval.kind     = hit_of(req_i.action);
  assign eval.operand  = req_i.operand;
  assign eval.position = req_i.position;

  // row of cells
  assign seen_w[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_head
      assign left = op_q;
    end else begin : g_mid
      assign left = entry_w[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = entry_w[i+1];
    end

    dwsr_cell #(
      .Depth (Depth),
      .Idx   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .eval_i  (eval),
      .upd_i   (upd),
      .count_i (cnt_q),
      .left_i  (left),
      .right_i (right),
      .seen_i  (seen_w[i]),
      .seen_o  (seen_w[i+1]),
      .first_o (first_w[i]),
      .entry_o (entry_w[i]),
      .sel_o   (sel_w[i])
    );
  end

  assign hit_any = seen_w[Depth];

  // gather the selected entry
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < Depth; i++) begin
      sel_val = sel_val | sel_w[i];
    end
  end

  // action decode for the apply cycle
  always_comb begin
    ok_d   = 1'b0;
    val_d  = VAL_FAIL;
    cnt_d  = cnt_q;
    mode_d = MODE_HOLD;
    case (act_q)
      ACT_APPEND, ACT_PUSH_FRONT: begin
        if (cnt_q != CntW'(Depth)) begin
          ok_d   = 1'b1;
          val_d  = op_q;
          cnt_d  = cnt_q + CntW'(1);
          mode_d = (act_q == ACT_APPEND) ? MODE_WRITE_TAIL : MODE_SHIFT_IN;
        end
      end
      ACT_POP_FRONT, ACT_REMOVE_EQ, ACT_TAKE_GREATER, ACT_TAKE_SMALLER: begin
        if (hit_any) begin
          ok_d   = 1'b1;
          val_d  = sel_val;
          cnt_d  = cnt_q - CntW'(1);
          mode_d = MODE_REMOVE;
        end
      end
      ACT_POP_BACK: begin
        if (hit_any) begin
          ok_d  = 1'b1;
          val_d = sel_val;
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ACT_PEEK_FRONT, ACT_PEEK_BACK, ACT_READ_INDEX, ACT_CONTAINS,
      ACT_HAS_GREATER, ACT_HAS_SMALLER: begin
        if (hit_any) begin
          ok_d  = 1'b1;
          val_d = sel_val;
        end
      end
      ACT_CLEAR: begin
        ok_d  = 1'b1;
        val_d = VAL_CLEAR;
        cnt_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // update broadcast
  assign upd.apply   = apply_fire;
  assign upd.mode    = mode_d;
  assign upd.operand = op_q;

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (apply_fire) begin
      cnt_q <= cnt_d;
    end
  end

  // output register
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (apply_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      rsp_ok_q  <= ok_d;
      rsp_val_q <= val_d;
      rsp_cnt_q <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.ok           = rsp_ok_q;
  assign rsp_o.result_value = rsp_val_q;
  assign rsp_o.count        = rsp_cnt_q;

  // checks
  `DWSR_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Depth))
  `DWSR_ASSERT_NOW(a_first_unique, clk_i, rst_ni, 1'b1, $onehot0(first_w))
  `DWSR_ASSERT_NEXT(a_accept_to_apply, clk_i, rst_ni, req_fire, state_q == ST_APPLY)
  `DWSR_ASSERT_NEXT(a_remove_shrinks, clk_i, rst_ni,
    apply_fire && ok_d && (mode_d == MODE_REMOVE), cnt_q == $past(cnt_q) - CntW'(1))

endmodule

`default_nettype wire

/* design/dwsr_cell.sv */
// ----------------------------------------------------------------------------
// dwsr_cell
// One slot of the deque: holds an entry, flags a hit, joins the
// first-match chain and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dwsr_cell #(
  parameter int unsigned Depth = dwsr_pkg::DEPTH_DEF,
  parameter int unsigned Idx   = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dwsr_pkg::cell_eval_t                eval_i,
  input  wire dwsr_pkg::cell_upd_t                 upd_i,
  input  wire logic [$clog2(Depth+1)-1:0]          count_i,
  input  wire logic [dwsr_pkg::DATA_W-1:0]         left_i,
  input  wire logic [dwsr_pkg::DATA_W-1:0]         right_i,
  input  wire logic                                seen_i,
  output logic                                     seen_o,
  output logic                                     first_o,
  output logic [dwsr_pkg::DATA_W-1:0]              entry_o,
  output logic [dwsr_pkg::DATA_W-1:0]              sel_o
);
  import dwsr_pkg::*;

  localparam int unsigned CntW = $clog2(Depth+1);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              hit_q, hit_d;
  logic              occ;

  // slot holds a live entry
  assign occ = (CntW'(Idx) < count_i);

  // compare against the incoming request
  always_comb begin
    hit_d = hit_q;
    if (eval_i.load) begin
      case (eval_i.kind)
        HIT_EQ:    hit_d = occ && (entry_q == eval_i.operand);
        HIT_GT:    hit_d = occ && ($signed(entry_q) > $signed(eval_i.operand));
        HIT_LT:    hit_d = occ && ($signed(entry_q) < $signed(eval_i.operand));
        HIT_POS:   hit_d = occ && (eval_i.position == POSITION_W'(Idx));
        HIT_FRONT: hit_d = occ && (Idx == 0);
        HIT_BACK:  hit_d = occ && (CntW'(Idx + 1) == count_i);
        default:   hit_d = 1'b0;
      endcase
    end
  end

  // first-match chain
  assign seen_o  = seen_i | hit_q;
  assign first_o = hit_q & ~seen_i;
  assign sel_o   = first_o ? entry_q : '0;
  assign entry_o = entry_q;

  // entry update: shift in, close a gap, or write at the tail
  always_comb begin
    entry_d = entry_q;
    if (upd_i.apply) begin
      case (upd_i.mode)
        MODE_SHIFT_IN:   entry_d = left_i;
        MODE_REMOVE:     if (seen_o) entry_d = right_i;
        MODE_WRITE_TAIL: if (CntW'(Idx) == count_i) entry_d = upd_i.operand;
        default:         entry_d = entry_q;
      endcase
    end
  end

  // hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire
